// ===== rtl/jsau_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the JSON string-array unescaper.
// Depends on nothing; used by the front end, the command queue and the back end.
package jsau_pkg;

  typedef enum logic [1:0] {
    KindByte    = 2'd0,
    KindElemEnd = 2'd1,
    KindFinish  = 2'd2
  } kind_e;

  localparam logic [7:0] ChOpenBracket = 8'h5B;
  localparam logic [7:0] ChQuote       = 8'h22;
  localparam logic [7:0] ChComma       = 8'h2C;
  localparam logic [7:0] ChBackslash   = 8'h5C;
  localparam logic [7:0] ChSpace       = 8'h20;
  localparam logic [7:0] ChTab         = 8'h09;
  localparam logic [7:0] ChCr          = 8'h0D;
  localparam logic [7:0] ChLf          = 8'h0A;
  localparam logic [7:0] ChLowerN      = 8'h6E;
  localparam logic [7:0] ChLowerR      = 8'h72;
  localparam logic [7:0] ChLowerT      = 8'h74;
  localparam logic [7:0] ChLowerU      = 8'h75;

  localparam logic [7:0]  Utf8Lead2    = 8'hC0;
  localparam logic [7:0]  Utf8Lead3    = 8'hE0;
  localparam logic [7:0]  Utf8Cont     = 8'h80;
  localparam logic [15:0] CpLimit1     = 16'h0080;
  localparam logic [15:0] CpLimit2     = 16'h0800;

  // One accepted text byte worth of results: up to three content bytes,
  // then an optional element end, then an optional finish marker.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            elem_end;
    logic            finish;
  } cmd_t;

endpackage

// ===== rtl/jsau_text_if.sv =====
`timescale 1ns / 1ps
// Input channel: one text byte per transaction.
// Depends on nothing.
interface jsau_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_end;

  modport source (output valid, text_byte, text_end, input ready);
  modport sink   (input valid, text_byte, text_end, output ready);
endinterface

// ===== rtl/jsau_result_if.sv =====
`timescale 1ns / 1ps
// Output channel: one decoded byte or marker per transaction.
// Depends on nothing.
interface jsau_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last_of_run;

  modport source (output valid, out_byte, kind, last_of_run, input ready);
  modport sink   (input valid, out_byte, kind, last_of_run, output ready);
endinterface

// ===== rtl/jsau_cmd_fifo.sv =====
`timescale 1ns / 1ps
// Short command queue between the parser front end and the output sequencer.
// Depends on jsau_pkg.
module jsau_cmd_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsau_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output jsau_pkg::cmd_t cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  jsau_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(Depth - 1)) return '0;
    return p + PtrW'(1);
  endfunction

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full command queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty command queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("command queue count out of range");

endmodule

// ===== rtl/jsau_front.sv =====
`timescale 1ns / 1ps
// Parser front end: tracks the array/string/escape state per text byte; each
// byte that yields results becomes one queued command. Depends on jsau_pkg, jsau_text_if.
module jsau_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  jsau_text_if.sink      text_i,
  input  logic           full_i,
  output logic           push_o,
  output jsau_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ModeOpen, ModeElem, ModeAfter, ModeStr, ModeEsc, ModeHex, ModeStop
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [11:0] val_q, val_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [7:0]  held_q [3];
  logic [7:0]  held_d [3];

  logic        accept;
  logic [7:0]  b;
  logic        is_end;
  logic [3:0]  dig;
  logic        ws;
  logic [15:0] cp;

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return 4'(c - 8'h57);
    if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h37);
    return 4'd0;
  endfunction

  assign text_i.ready = !full_i;
  assign accept = text_i.valid && text_i.ready;
  assign b      = text_i.text_byte;
  assign is_end = text_i.text_end;
  assign dig    = hex_digit(b);
  assign ws     = (b == jsau_pkg::ChSpace) || (b >= jsau_pkg::ChTab && b <= jsau_pkg::ChCr);
  assign cp     = {val_q, dig};

  always_comb begin
    mode_d = mode_q;
    val_d  = val_q;
    cnt_d  = cnt_q;
    held_d = held_q;
    cmd_o  = '0;

    unique case (mode_q)
      ModeOpen: begin
        if (!ws) mode_d = (b == jsau_pkg::ChOpenBracket) ? ModeElem : ModeStop;
      end
      ModeElem: begin
        if (!ws) mode_d = (b == jsau_pkg::ChQuote) ? ModeStr : ModeStop;
      end
      ModeAfter: begin
        if (!ws) begin
          if (b == jsau_pkg::ChComma) mode_d = ModeElem;
          else if (b == jsau_pkg::ChQuote) mode_d = ModeStr;
          else mode_d = ModeStop;
        end
      end
      ModeStr: begin
        if (b == jsau_pkg::ChQuote) begin
          cmd_o.elem_end = 1'b1;
          mode_d = ModeAfter;
        end else if (b == jsau_pkg::ChBackslash && !is_end) begin
          mode_d = ModeEsc;
        end else begin
          cmd_o.bytes[0] = b;
          cmd_o.nbytes   = 2'd1;
        end
      end
      ModeEsc: begin
        mode_d       = ModeStr;
        cmd_o.nbytes = 2'd1;
        unique case (b)
          jsau_pkg::ChLowerN: cmd_o.bytes[0] = jsau_pkg::ChLf;
          jsau_pkg::ChLowerR: cmd_o.bytes[0] = jsau_pkg::ChCr;
          jsau_pkg::ChLowerT: cmd_o.bytes[0] = jsau_pkg::ChTab;
          jsau_pkg::ChLowerU: begin
            cmd_o.nbytes = 2'd0;
            mode_d = ModeHex;
            val_d  = '0;
            cnt_d  = '0;
          end
          default: cmd_o.bytes[0] = b;
        endcase
      end
      ModeHex: begin
        if (cnt_q == 2'd3) begin
          mode_d = ModeStr;
          val_d  = '0;
          cnt_d  = '0;
          if (cp < jsau_pkg::CpLimit1) begin
            cmd_o.bytes[0] = cp[7:0];
            cmd_o.nbytes   = 2'd1;
          end else if (cp < jsau_pkg::CpLimit2) begin
            cmd_o.bytes[0] = jsau_pkg::Utf8Lead2 | {3'b000, cp[10:6]};
            cmd_o.bytes[1] = jsau_pkg::Utf8Cont | {2'b00, cp[5:0]};
            cmd_o.nbytes   = 2'd2;
          end else begin
            cmd_o.bytes[0] = jsau_pkg::Utf8Lead3 | {4'b0000, cp[15:12]};
            cmd_o.bytes[1] = jsau_pkg::Utf8Cont | {2'b00, cp[11:6]};
            cmd_o.bytes[2] = jsau_pkg::Utf8Cont | {2'b00, cp[5:0]};
            cmd_o.nbytes   = 2'd3;
          end
        end else begin
          held_d[cnt_q] = b;
          val_d = {val_q[7:0], dig};
          cnt_d = cnt_q + 2'd1;
        end
      end
      default: ;
    endcase

    if (is_end) begin
      if (mode_d == ModeStr || mode_d == ModeEsc || mode_d == ModeHex) begin
        cmd_o.elem_end = 1'b1;
      end
      // a cut-short \u flushes its held digits as plain bytes
      if (mode_d == ModeHex) begin
        cmd_o.bytes[0] = held_d[0];
        cmd_o.bytes[1] = held_d[1];
        cmd_o.bytes[2] = held_d[2];
        cmd_o.nbytes   = cnt_d;
      end
      cmd_o.finish = 1'b1;
      mode_d = ModeOpen;
      val_d  = '0;
      cnt_d  = '0;
    end
  end

  assign push_o = accept && (cmd_o.nbytes != 2'd0 || cmd_o.elem_end || cmd_o.finish);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeOpen;
      val_q  <= '0;
      cnt_q  <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      val_q  <= val_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

  a_hex_count_only_in_hex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != ModeHex) |-> (cnt_q == 2'd0)) else $error("hex digits held outside \\u");

endmodule

// ===== rtl/jsau_back.sv =====
`timescale 1ns / 1ps
// Output sequencer: expands the command at the queue head into results,
// one transaction per cycle while the receiver is ready. Depends on jsau_pkg, jsau_result_if.
module jsau_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  jsau_pkg::cmd_t cmd_i,
  output logic           pop_o,
  jsau_result_if.source  result_o
);

  logic [2:0] pos_q, pos_d;
  logic [2:0] total;
  logic       last;
  logic       fire;

  assign total = {1'b0, cmd_i.nbytes} + {2'b00, cmd_i.elem_end} + {2'b00, cmd_i.finish};
  assign last  = (pos_q == total - 3'd1);
  assign fire  = result_o.valid && result_o.ready;
  assign pop_o = fire && last;

  assign result_o.valid       = !empty_i;
  assign result_o.last_of_run = last;

  always_comb begin
    if (pos_q < {1'b0, cmd_i.nbytes}) begin
      result_o.out_byte = cmd_i.bytes[pos_q[1:0]];
      result_o.kind     = jsau_pkg::KindByte;
    end else if (cmd_i.elem_end && pos_q == {1'b0, cmd_i.nbytes}) begin
      result_o.out_byte = '0;
      result_o.kind     = jsau_pkg::KindElemEnd;
    end else begin
      result_o.out_byte = '0;
      result_o.kind     = jsau_pkg::KindFinish;
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (fire) pos_d = last ? 3'd0 : pos_q + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (pos_q < total)) else $error("sequencer position beyond command");
  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (pos_q == 3'd0)) else $error("sequencer did not restart after last");

endmodule

// ===== rtl/json_string_array_unescaper_unit.sv =====
`timescale 1ns / 1ps
// JSON string-array unescaper, top level.
// Channels: text_i takes one text byte per transaction (text_byte, text_end);
// result_o gives one result per transaction: out_byte, kind (content byte,
// element end, finish) and last_of_run on the final result of a text byte.
// A text byte is taken in every cycle while the command queue has room; the
// parser state is a single register loop, so bytes follow back to back.
// Each byte that yields results becomes one queue entry; its first result is
// offered once that entry reaches the queue head, and a byte with k results
// gives k result transactions (k at most 5, only multi-byte \u escapes and the end
// of text give more than one). Sustained rate: one text byte per cycle while
// results stay at about one per byte.
// When the receiver stalls, up to FifoDepth commands collect in the queue,
// after which text_i.ready drops until an entry drains.
// Reset empties the queue and returns the parser to waiting for '['; the end
// of each text returns the parser to waiting for '[' for the following text.
// Depends on jsau_pkg, jsau_text_if, jsau_result_if and the submodules.
module json_string_array_unescaper_unit #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  jsau_text_if.sink     text_i,
  jsau_result_if.source result_o
);

  logic           push, pop, full, empty;
  jsau_pkg::cmd_t push_cmd, head_cmd;

  jsau_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .text_i (text_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  jsau_cmd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (head_cmd)
  );

  jsau_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .cmd_i    (head_cmd),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule

// ===== tb/json_string_array_unescaper_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for json_string_array_unescaper_unit: drives JSON text bytes,
// predicts every decoded byte and marker and compares each result transaction.
// Depends on jsau_pkg, jsau_text_if, jsau_result_if and the unit itself.
module json_string_array_unescaper_unit_test;

  localparam logic [7:0] ChCloseBracket = 8'h5D;
  localparam logic [7:0] ChSlash        = 8'h2F;
  localparam int unsigned CycleLimit    = 300000;
  localparam int unsigned TargetBytes   = 420;
  localparam int unsigned HoldAt        = 180;
  localparam int unsigned HoldCycles    = 300;

  typedef enum logic [2:0] {
    PmOpen, PmElem, PmAfter, PmStr, PmEsc, PmHex, PmStop
  } parse_mode_e;

  typedef struct packed {
    logic [7:0]      out_byte;
    jsau_pkg::kind_e kind;
    logic            last_of_run;
  } decoded_t;

  typedef struct {
    logic [7:0] text_byte;
    logic       text_end;
    int         pace;
  } text_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #10 clk_i = ~clk_i;

  jsau_text_if   text_bus ();
  jsau_result_if result_bus ();

  json_string_array_unescaper_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .text_i  (text_bus),
    .result_o(result_bus)
  );

  // pace 0: no idling, 1: sender idle, 2: receiver stalls, 3: both lightly
  int send_idle_pct [4] = '{0, 72, 0, 8};
  int recv_idle_pct [4] = '{0, 0, 72, 8};

  text_item_t  pending_text[$];
  decoded_t    expected_results[$];
  decoded_t    run_q[$];
  logic [7:0]  text_buf[$];

  parse_mode_e pm = PmOpen;
  logic [15:0] hex_acc = '0;
  logic [2:0]  hex_n = '0;
  logic [7:0]  held_hex[4] = '{default: 8'h00};

  int          pace;
  int unsigned bytes_taken;
  int unsigned hold_left;
  logic        hold_done;
  int unsigned results_seen = 0;
  int unsigned markers_seen = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned n_texts = 0;

  function automatic logic is_blank(input logic [7:0] b);
    return b == jsau_pkg::ChSpace || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  task automatic put(input logic [7:0] b, input jsau_pkg::kind_e k);
    decoded_t d;
    d = '{out_byte: b, kind: k, last_of_run: 1'b0};
    if (run_q.size() < 6) run_q = {run_q, d};
  endtask

  task automatic clear_parser();
    pm      = PmOpen;
    hex_acc = '0;
    hex_n   = '0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    logic [3:0]  nib;
    logic [15:0] cp;
    run_q.delete();
    case (pm)
      PmOpen: if (!is_blank(b)) pm = (b == jsau_pkg::ChOpenBracket) ? PmElem : PmStop;
      PmElem: if (!is_blank(b)) pm = (b == jsau_pkg::ChQuote) ? PmStr : PmStop;
      PmAfter: begin
        if (!is_blank(b)) begin
          if (b == jsau_pkg::ChComma) pm = PmElem;
          else if (b == jsau_pkg::ChQuote) pm = PmStr;
          else pm = PmStop;
        end
      end
      PmStr: begin
        if (b == jsau_pkg::ChQuote) begin
          put(8'h00, jsau_pkg::KindElemEnd);
          pm = PmAfter;
        end else if (b == jsau_pkg::ChBackslash) begin
          if (last) put(b, jsau_pkg::KindByte);
          else pm = PmEsc;
        end else begin
          put(b, jsau_pkg::KindByte);
        end
      end
      PmEsc: begin
        pm = PmStr;
        case (b)
          jsau_pkg::ChLowerN: put(jsau_pkg::ChLf, jsau_pkg::KindByte);
          jsau_pkg::ChLowerR: put(jsau_pkg::ChCr, jsau_pkg::KindByte);
          jsau_pkg::ChLowerT: put(jsau_pkg::ChTab, jsau_pkg::KindByte);
          jsau_pkg::ChLowerU: begin
            pm      = PmHex;
            hex_acc = '0;
            hex_n   = '0;
          end
          default: put(b, jsau_pkg::KindByte);
        endcase
      end
      PmHex: begin
        held_hex[hex_n[1:0]] = b;
        if (b >= "0" && b <= "9") nib = 4'(b - "0");
        else if (b >= "a" && b <= "f") nib = 4'(b - "a" + 8'd10);
        else if (b >= "A" && b <= "F") nib = 4'(b - "A" + 8'd10);
        else nib = 4'h0;
        hex_acc = {hex_acc[11:0], nib};
        hex_n   = hex_n + 3'd1;
        if (hex_n >= 3'd4) begin
          cp = hex_acc;
          if (cp < jsau_pkg::CpLimit1) begin
            put(cp[7:0], jsau_pkg::KindByte);
          end else if (cp < jsau_pkg::CpLimit2) begin
            put(jsau_pkg::Utf8Lead2 | {3'b000, cp[10:6]}, jsau_pkg::KindByte);
            put(jsau_pkg::Utf8Cont | {2'b00, cp[5:0]}, jsau_pkg::KindByte);
          end else begin
            put(jsau_pkg::Utf8Lead3 | {4'b0000, cp[15:12]}, jsau_pkg::KindByte);
            put(jsau_pkg::Utf8Cont | {2'b00, cp[11:6]}, jsau_pkg::KindByte);
            put(jsau_pkg::Utf8Cont | {2'b00, cp[5:0]}, jsau_pkg::KindByte);
          end
          hex_n   = '0;
          hex_acc = '0;
          pm      = PmStr;
        end
      end
      default: ;
    endcase
    if (last) begin
      if (pm == PmStr || pm == PmEsc || pm == PmHex) begin
        if (pm == PmHex) begin
          for (int k = 0; k < hex_n && k < 4; k++) put(held_hex[k], jsau_pkg::KindByte);
        end
        put(8'h00, jsau_pkg::KindElemEnd);
      end
      put(8'h00, jsau_pkg::KindFinish);
      clear_parser();
    end
    if (run_q.size() != 0) run_q[run_q.size() - 1].last_of_run = 1'b1;
    expected_results = {expected_results, run_q};
  endtask

  task automatic add(input logic [7:0] b);
    text_buf = {text_buf, b};
  endtask

  task automatic add_blanks();
    int n;
    n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: add(jsau_pkg::ChSpace);
        1: add(jsau_pkg::ChTab);
        2: add(jsau_pkg::ChLf);
        default: add(8'(8'h0B + $urandom_range(0, 2)));
      endcase
    end
  endtask

  task automatic add_hex_nibble(input logic [3:0] n);
    if (n < 4'd10) add("0" + {4'h0, n});
    else if ($urandom_range(0, 1)) add("A" + {4'h0, n} - 8'd10);
    else add("a" + {4'h0, n} - 8'd10);
  endtask

  task automatic add_chunk();
    logic [7:0]  b;
    logic [15:0] cp;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        b = 8'($urandom_range(8'h20, 8'h7E));
        if (b == jsau_pkg::ChQuote || b == jsau_pkg::ChBackslash) b = "x";
        add(b);
      end
      4: begin
        b = 8'($urandom_range(0, 255));
        if (b == jsau_pkg::ChQuote || b == jsau_pkg::ChBackslash) b = 8'hFF;
        add(b);
      end
      5: begin
        add(jsau_pkg::ChBackslash);
        case ($urandom_range(0, 7))
          0: add(jsau_pkg::ChLowerN);
          1: add(jsau_pkg::ChLowerR);
          2: add(jsau_pkg::ChLowerT);
          3: add(jsau_pkg::ChQuote);
          4: add(jsau_pkg::ChBackslash);
          5: add(ChSlash);
          default: begin
            b = 8'($urandom_range(0, 255));
            if (b == jsau_pkg::ChLowerU) b = "q";
            add(b);
          end
        endcase
      end
      6, 7, 8: begin
        add(jsau_pkg::ChBackslash);
        add(jsau_pkg::ChLowerU);
        case ($urandom_range(0, 4))
          0: cp = 16'($urandom_range(0, 16'h007F));
          1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
          2: cp = $urandom_range(0, 1) ? 16'hFFFF : 16'h0800;
          default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
        for (int i = 3; i >= 0; i--) begin
          // occasional bad digit, read as zero
          if ($urandom_range(0, 15) == 0) add(8'("g" + $urandom_range(0, 12)));
          else add_hex_nibble(cp[4*i +: 4]);
        end
      end
      default: add($urandom_range(0, 1) ? jsau_pkg::ChTab : jsau_pkg::ChLf);
    endcase
  endtask

  task automatic build_array();
    int n_elem;
    int n_chunk;
    text_buf.delete();
    add_blanks();
    add(jsau_pkg::ChOpenBracket);
    n_elem = $urandom_range(0, 4);
    for (int e = 0; e < n_elem; e++) begin
      add_blanks();
      add(jsau_pkg::ChQuote);
      n_chunk = $urandom_range(0, 6);
      repeat (n_chunk) add_chunk();
      add(jsau_pkg::ChQuote);
      add_blanks();
      if ($urandom_range(0, 3) != 0) add(jsau_pkg::ChComma);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        add_blanks();
        add(ChCloseBracket);
        repeat ($urandom_range(0, 3)) add(8'($urandom_range(0, 255)));
      end
      6, 7: begin
        add(jsau_pkg::ChQuote);
        repeat ($urandom_range(1, 3)) add_chunk();
      end
      default: ;
    endcase
  endtask

  task automatic commit_text(input int keep, input int text_pace);
    text_item_t item;
    for (int i = 0; i < keep; i++) begin
      item = '{text_byte: text_buf[i], text_end: (i == keep - 1), pace: text_pace};
      pending_text = {pending_text, item};
    end
    n_texts++;
  endtask

  // Driver: offers pending bytes, holds each until taken, predicts on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_bus.valid     <= 1'b0;
      text_bus.text_byte <= '0;
      text_bus.text_end  <= 1'b0;
      bytes_taken        <= 0;
      pace               <= 0;
    end else begin
      if (text_bus.valid && text_bus.ready) begin
        predict_byte(text_bus.text_byte, text_bus.text_end);
        void'(pending_text.pop_front());
        bytes_taken <= bytes_taken + 1;
      end
      if (text_bus.valid && !text_bus.ready) begin
        // keep offering the same byte
      end else if (pending_text.size() != 0 &&
                   $urandom_range(0, 99) >= send_idle_pct[pending_text[0].pace]) begin
        text_bus.valid     <= 1'b1;
        text_bus.text_byte <= pending_text[0].text_byte;
        text_bus.text_end  <= pending_text[0].text_end;
        pace               <= pending_text[0].pace;
      end else begin
        text_bus.valid <= 1'b0;
      end
    end
  end

  // One long receiver hold-off so the command queue fills and input stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && bytes_taken >= HoldAt) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks each result transaction against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    decoded_t want;
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        results_seen++;
        if (result_bus.kind != jsau_pkg::KindByte) markers_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result byte=%02h kind=%0d last=%0b", $time,
                   result_bus.out_byte, result_bus.kind, result_bus.last_of_run);
        end else begin
          want = expected_results.pop_front();
          if (want.out_byte !== result_bus.out_byte || want.kind !== result_bus.kind ||
              want.last_of_run !== result_bus.last_of_run) begin
            errors++;
            $display("%0t: mismatch expected byte=%02h kind=%0d last=%0b,",
                     $time, want.out_byte, want.kind, want.last_of_run,
                     " got byte=%02h kind=%0d last=%0b",
                     result_bus.out_byte, result_bus.kind, result_bus.last_of_run);
          end
        end
      end
      result_bus.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct[pace]);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("%0t: timeout, %0d bytes left to send, %0d results outstanding", $time,
               pending_text.size(), expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int r;

    // three-byte UTF-8 escape completed by the last byte
    text_buf = '{jsau_pkg::ChTab, jsau_pkg::ChOpenBracket, jsau_pkg::ChQuote,
                 jsau_pkg::ChBackslash, jsau_pkg::ChLowerU, "2", "0", "A", "C"};
    commit_text(text_buf.size(), 0);
    // zero and all-ones bytes, then a backslash as last byte
    text_buf = '{jsau_pkg::ChOpenBracket, jsau_pkg::ChQuote, 8'h00, 8'hFF,
                 jsau_pkg::ChBackslash};
    commit_text(text_buf.size(), 0);
    // short unicode escape cut after one digit, and after none
    text_buf = '{jsau_pkg::ChOpenBracket, jsau_pkg::ChQuote, jsau_pkg::ChBackslash,
                 jsau_pkg::ChLowerU, "4"};
    commit_text(text_buf.size(), 0);
    text_buf = '{jsau_pkg::ChOpenBracket, jsau_pkg::ChQuote, jsau_pkg::ChBackslash,
                 jsau_pkg::ChLowerU};
    commit_text(text_buf.size(), 0);
    // leading comma, then doubled comma with bytes after the stop
    text_buf = '{jsau_pkg::ChOpenBracket, jsau_pkg::ChComma};
    commit_text(text_buf.size(), 0);
    text_buf = '{jsau_pkg::ChOpenBracket, jsau_pkg::ChQuote, jsau_pkg::ChQuote,
                 jsau_pkg::ChComma, jsau_pkg::ChComma, jsau_pkg::ChQuote, "x"};
    commit_text(text_buf.size(), 0);

    while (pending_text.size() < TargetBytes) begin
      r = $urandom_range(0, 19);
      if (r < 14) begin
        build_array();
        commit_text(text_buf.size(), (n_texts / 5) % 4);
      end else if (r < 17) begin
        build_array();
        commit_text($urandom_range(1, text_buf.size()), (n_texts / 5) % 4);
      end else begin
        text_buf.delete();
        if ($urandom_range(0, 1)) add(jsau_pkg::ChOpenBracket);
        repeat ($urandom_range(1, 8)) add(8'($urandom_range(0, 255)));
        commit_text(text_buf.size(), (n_texts / 5) % 4);
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_text.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d text bytes in %0d texts under four pacing modes and one long stall;",
             bytes_taken, n_texts);
    $display("checked %0d results, %0d of them markers, %0d errors.",
             results_seen, markers_seen, errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
